FILE: sv/mbp_pkg.sv
// Package with the shared types and constants of the MSB-first bit packer.
`timescale 1ns / 1ps

package mbp_pkg;

  localparam int BYTE_W = 8;

  // Function codes carried in the input tuser.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // Merge a write beat into the shift register.
    logic emit_write;  // Send the top byte of the shift register.
    logic finish;      // Park the leftover bits as the partial byte.
    logic emit_flush;  // Send the partial byte and clear it.
  } mbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_ge8;   // At least one full byte is waiting.
    logic fill_nz;   // The partial byte holds pending bits.
    logic out_free;  // The output register can take a new beat.
  } mbp_status_t;

endpackage

FILE: sv/mbp_ctrl.sv
// Controller state machine of the MSB-first bit packer.
`timescale 1ns / 1ps

module mbp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               func,
  input  mbp_pkg::mbp_status_t status,
  output mbp_pkg::mbp_cmd_t    cmd
);
  import mbp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EMIT  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_WRITE) begin
            cmd.load   = 1'b1;
            state_next = ST_EMIT;
          end else if (status.fill_nz) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_EMIT: begin
        if (!status.rem_ge8) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit_write = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.emit_flush = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/mbp_dpath.sv
// Datapath of the MSB-first bit packer: shift register, partial byte, counter, output beat.
`timescale 1ns / 1ps

module mbp_dpath #(
  parameter int MAX_WRITE_BITS = 64,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [63:0]          value_bits,
  input  logic [6:0]           bit_count,
  input  mbp_pkg::mbp_cmd_t    cmd,
  output mbp_pkg::mbp_status_t status,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,
  output logic                 m_tlast
);
  import mbp_pkg::*;

  localparam int AW = MAX_WRITE_BITS + BYTE_W;   // Shift register width.
  localparam int RW = $clog2(AW);                // Pending bit count width.
  localparam int SW = $clog2(AW + 1);            // Alignment shift width.
  localparam logic [6:0] MAX_N = 7'(MAX_WRITE_BITS);

  logic [AW-1:0]          acc;
  logic [RW-1:0]          rem;
  logic [BYTE_W-1:0]      partial_byte;
  logic [2:0]             fill_position;
  logic [COUNT_WIDTH-1:0] byte_counter;
  logic [COUNT_WIDTH-1:0] counter_next;

  logic [6:0]                sat_n;
  logic [RW-1:0]             n_rw;
  logic [63:0]               masked;
  logic [SW-1:0]             shamt;
  logic [AW-1:0]             load_acc;
  logic [COUNT_WIDTH+31:0]   count_ext;
  logic [BYTE_W-1:0]         out_byte;
  logic [31:0]               total_bytes;

  // Saturate the count and keep only the bits that take part.
  always_comb begin
    sat_n = (bit_count > MAX_N) ? MAX_N : bit_count;
    for (int j = 0; j < 64; j++) begin
      masked[j] = value_bits[j] & (j < int'(sat_n));
    end
  end

  // Line the new bits up right behind the pending bits of the partial byte.
  assign n_rw     = RW'(sat_n);
  assign shamt    = SW'(AW) - SW'(sat_n) - SW'(fill_position);
  assign load_acc = ({{BYTE_W{1'b0}}, masked[MAX_WRITE_BITS-1:0]} << shamt)
                  | {partial_byte, {MAX_WRITE_BITS{1'b0}}};

  assign status.rem_ge8  = |rem[RW-1:3];
  assign status.fill_nz  = (fill_position != 3'd0);
  assign status.out_free = !m_tvalid || m_tready;

  assign counter_next = byte_counter + COUNT_WIDTH'(1);

  // Shift register and pending bit count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (cmd.load) begin
      acc <= load_acc;
      rem <= RW'(fill_position) + n_rw;
    end else if (cmd.emit_write) begin
      acc <= {acc[AW-BYTE_W-1:0], {BYTE_W{1'b0}}};
      rem <= rem - RW'(BYTE_W);
    end
  end

  // Partial byte, fill position and byte counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_byte  <= '0;
      fill_position <= '0;
      byte_counter  <= '0;
    end else begin
      if (cmd.finish) begin
        partial_byte  <= acc[AW-1 -: BYTE_W];
        fill_position <= rem[2:0];
      end else if (cmd.emit_flush) begin
        partial_byte  <= '0;
        fill_position <= '0;
      end
      if (cmd.emit_write) begin
        byte_counter <= counter_next;
      end
    end
  end

  // Output beat register.
  assign count_ext = {32'd0, (cmd.emit_write ? counter_next : byte_counter)};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_write || cmd.emit_flush) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_write || cmd.emit_flush) begin
      out_byte    <= cmd.emit_write ? acc[AW-1 -: BYTE_W] : partial_byte;
      m_tlast     <= cmd.emit_flush || (rem[RW-1:3] == (RW-3)'(1));
      total_bytes <= count_ext[31:0];
    end
  end

  assign m_tdata = {total_bytes, out_byte};

  // Bits below the fill position of the partial byte stay zero.
  a_partial_clean: assert property (@(posedge clk) disable iff (rst)
    (partial_byte & (8'hFF >> fill_position)) == 8'h00)
    else $error("partial byte has bits below the fill position");

  // A new beat never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_write || cmd.emit_flush) |-> (!m_tvalid || m_tready))
    else $error("output beat overwritten while stalled");

  // The pending bit count never exceeds one partial byte plus a full write.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    32'(rem) <= 32'(AW - 1))
    else $error("pending bit count out of range");

endmodule

FILE: sv/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: controller and datapath.
//
// Input channel (s_*): one beat per item. s_tuser is the function: 0
// appends the low bit_count bits of value_bits, most significant bit first,
// and 1 flushes the pending partial byte zero padded at the low end.
// Output channel (m_*): one beat per completed byte. m_tlast marks the
// final byte caused by an input beat; total_bytes is the count of bytes
// completed by writes, including this one (a flush byte shows the
// unchanged count). The counter wraps at COUNT_WIDTH bits.
// Counts above MAX_WRITE_BITS saturate to MAX_WRITE_BITS.
// Timing: a write beat loads the shift register, then the output register
// takes the bytes it completes (0 to 8), one byte per cycle while the
// receiver does not stall, and the leftover bits are parked as the partial
// byte. A flush uses the flush state only if bits are pending. One item is
// worked on at a time; s_tready is high only while the block is idle.
// When the receiver stalls, the held beat waits in the output register and
// the controller pauses. Reset clears the partial byte, the fill position,
// the counter and the output valid.
`timescale 1ns / 1ps

module msb_first_bit_packer #(
  parameter int MAX_WRITE_BITS = 64,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // value_bits [63:0], bit_count [70:64], zero [71]
  input  logic        s_tuser,   // func [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_byte [7:0], total_bytes [39:8]
  output logic        m_tlast    // last
);
  import mbp_pkg::*;

  mbp_cmd_t    cmd;
  mbp_status_t status;

  mbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  mbp_dpath #(
    .MAX_WRITE_BITS (MAX_WRITE_BITS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .value_bits (s_tdata[63:0]),
    .bit_count  (s_tdata[70:64]),
    .cmd        (cmd),
    .status     (status),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the MSB-first bit packer: directed table, then random beats.
`timescale 1ns / 1ps

module tb_top;
  import mbp_pkg::*;

  localparam int MAX_BITS   = 64;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 20;

  // One byte the packer should emit.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] total_bytes;
  } byte_beat_t;

  // One row of the directed table. Rows with typed set carry their own result.
  typedef struct packed {
    logic        func;
    logic [63:0] value_bits;
    logic [6:0]  bit_count;
    logic        typed;
    logic        has_byte;
    logic [7:0]  exp_byte;
    logic [31:0] exp_total;
  } stim_row_t;

  localparam int N_ROWS = 22;

  stim_row_t dir_rows [0:N_ROWS-1] = '{
    '{FUNC_WRITE, 64'hA5,                  7'd8,   1'b1, 1'b1, 8'hA5, 32'd1},
    '{FUNC_WRITE, 64'h0,                   7'd0,   1'b1, 1'b0, 8'h00, 32'd0},
    '{FUNC_FLUSH, 64'h0,                   7'd0,   1'b1, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'h5,                   7'd3,   1'b1, 1'b0, 8'h00, 32'd0},
    '{FUNC_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b1, 1'b1, 8'hA0, 32'd1},
    '{FUNC_FLUSH, 64'h0,                   7'd0,   1'b1, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64,  1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'h8000_0000_0000_0001, 7'd64,  1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'h1,                   7'd1,   1'b1, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'h7F,                  7'd7,   1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'hFFFF_FFFF_FFFF_FF00, 7'd8,   1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'h0,                   7'd64,  1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'h3,                   7'd2,   1'b1, 1'b0, 8'h00, 32'd0},
    '{FUNC_FLUSH, 64'h0,                   7'd0,   1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'h0123_4567_89AB_CDEF, 7'd65,  1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'hF,                   7'd4,   1'b1, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'hDEAD_BEEF_CAFE_F00D, 7'd60,  1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd13,  1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_FLUSH, 64'h5555_5555_5555_5555, 7'd64,  1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'h5555_AAAA_5555_AAAA, 7'd96,  1'b0, 1'b0, 8'h00, 32'd0},
    '{FUNC_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   1'b1, 1'b0, 8'h00, 32'd0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  // Packer state kept by the testbench.
  logic [7:0]  pk_byte;
  int          pk_fill;
  logic [31:0] pk_count;

  byte_beat_t  expected_bytes [$];
  bit          quiet;
  int          n_errors;
  int          n_items;
  int          n_flushes;
  int          n_bytes;
  int          idle_cycles;

  msb_first_bit_packer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advance the packer state by one item; queue the bytes it emits if asked.
  task automatic pack_item(input logic func, input logic [63:0] value_bits,
                           input logic [6:0] bit_count, input bit record);
    byte_beat_t made [$];
    int         n;
    if (func == FUNC_FLUSH) begin
      if (pk_fill != 0) made.push_back('{pk_byte, 1'b1, pk_count});
      pk_byte = '0;
      pk_fill = 0;
    end else begin
      n = (bit_count > MAX_BITS) ? MAX_BITS : int'(bit_count);
      for (int i = n - 1; i >= 0; i--) begin
        pk_byte[7 - pk_fill] = value_bits[i];
        pk_fill++;
        if (pk_fill == 8) begin
          pk_count++;
          made.push_back('{pk_byte, 1'b0, pk_count});
          pk_byte = '0;
          pk_fill = 0;
        end
      end
      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
    end
    if (record) begin
      foreach (made[i]) expected_bytes.push_back(made[i]);
    end
  endtask

  // Present one input beat and wait for it to be taken.
  task automatic send_item(input logic func, input logic [63:0] value_bits,
                           input logic [6:0] bit_count, output bit taken);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {1'b0, bit_count, value_bits};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
    if (func == FUNC_FLUSH) n_flushes++;
    taken = 1'b1;
  endtask

  // Receiver side: random stalls on m_tready.
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = pick_gap();
      if (stall == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // Compare every output beat with the oldest expected byte.
  always @(posedge clk) begin
    byte_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_bytes++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output beat: out_byte %0h, total_bytes %0d",
               m_tdata[7:0], m_tdata[39:8]);
        n_errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata[7:0] !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, m_tdata[7:0]);
          n_errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          n_errors++;
        end
        if (m_tdata[39:8] !== want.total_bytes) begin
          $error("total_bytes: expected %0d, got %0d", want.total_bytes, m_tdata[39:8]);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles.", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    bit          taken;
    logic        func;
    logic [63:0] value_bits;
    logic [6:0]  bit_count;
    int          r;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = FUNC_WRITE;
    quiet       = 1'b0;
    n_items     = 0;
    n_flushes   = 0;
    pk_byte     = '0;
    pk_fill     = 0;
    pk_count    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].func, dir_rows[i].value_bits, dir_rows[i].bit_count, taken);
      pack_item(dir_rows[i].func, dir_rows[i].value_bits, dir_rows[i].bit_count,
                !dir_rows[i].typed);
      if (dir_rows[i].typed && dir_rows[i].has_byte)
        expected_bytes.push_back('{dir_rows[i].exp_byte, 1'b1, dir_rows[i].exp_total});
    end

    // Random beats, with every third stretch free of gaps on both sides.
    for (int i = 0; i < 150; i++) begin
      quiet = ((i / 25) % 3 == 2);
      func = ($urandom_range(0, 5) == 0) ? FUNC_FLUSH : FUNC_WRITE;
      value_bits = {$urandom, $urandom};
      r = $urandom_range(0, 9);
      if (r < 6)      bit_count = 7'($urandom_range(0, 64));
      else if (r < 9) bit_count = 7'($urandom_range(1, 12));
      else            bit_count = 7'($urandom_range(65, 127));
      send_item(func, value_bits, bit_count, taken);
      pack_item(func, value_bits, bit_count, 1'b1);
    end
    quiet = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain, then keep watching for stray beats.
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d input beats (%0d flushes) and %0d output bytes.",
             n_items, n_flushes, n_bytes);
    $display("Mismatches found: %0d.", n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
